// ===== sv/sacc_pkg.sv =====
// Shared types and register map of the sprite collision checker.
package sacc_pkg;

   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 8;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Register map
   localparam logic [ADDR_WIDTH-1:0] REG_AX_B0    = 5'h01;
   localparam logic [ADDR_WIDTH-1:0] REG_AX_B1    = 5'h02;
   localparam logic [ADDR_WIDTH-1:0] REG_AX_B2    = 5'h03;
   localparam logic [ADDR_WIDTH-1:0] REG_AX_DELTA = 5'h04;
   localparam logic [ADDR_WIDTH-1:0] REG_A_XEXT   = 5'h06;
   localparam logic [ADDR_WIDTH-1:0] REG_A_YEXT   = 5'h07;
   localparam logic [ADDR_WIDTH-1:0] REG_AY_B0    = 5'h09;
   localparam logic [ADDR_WIDTH-1:0] REG_AY_B1    = 5'h0A;
   localparam logic [ADDR_WIDTH-1:0] REG_AY_B2    = 5'h0B;
   localparam logic [ADDR_WIDTH-1:0] REG_AY_DELTA = 5'h0C;
   localparam logic [ADDR_WIDTH-1:0] REG_B_XEXT   = 5'h0E;
   localparam logic [ADDR_WIDTH-1:0] REG_B_YEXT   = 5'h0F;
   localparam logic [ADDR_WIDTH-1:0] REG_BY_B0    = 5'h11;
   localparam logic [ADDR_WIDTH-1:0] REG_BY_B1    = 5'h12;
   localparam logic [ADDR_WIDTH-1:0] REG_BY_B2    = 5'h13;
   localparam logic [ADDR_WIDTH-1:0] REG_BX_B0    = 5'h15;
   localparam logic [ADDR_WIDTH-1:0] REG_BX_B1    = 5'h16;
   localparam logic [ADDR_WIDTH-1:0] REG_BX_B2    = 5'h17;
   localparam logic [ADDR_WIDTH-1:0] REG_STATUS   = 5'h18;

   localparam logic [DATA_WIDTH-1:0] EXTENT_RESET = 8'h01;

   // Miss window on the signed position difference
   localparam logic signed [26:0] DIFF_MAX = 27'sd511;
   localparam logic signed [26:0] DIFF_MIN = -27'sd1023;

   // Operands of one axis test
   typedef struct packed {
      logic [23:0] a_base;
      logic [7:0]  a_delta;
      logic [23:0] b_base;
      logic [7:0]  a_extent;
      logic [7:0]  b_extent;
   } axis_type;

endpackage

// ===== sv/sacc_req_if.sv =====
// Request channel: one bus access per beat.
interface sacc_req_if;
   import sacc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [ADDR_WIDTH-1:0] register_address;
   logic [DATA_WIDTH-1:0] write_data;

   modport source (output valid, output func, output register_address,
                   output write_data, input ready);
   modport sink   (input valid, input func, input register_address,
                   input write_data, output ready);
endinterface

// ===== sv/sacc_rsp_if.sv =====
// Response channel: one read byte per beat.
interface sacc_rsp_if;
   import sacc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

// ===== sv/sacc_regs.sv =====
// Position and extent register file with write decode.
module sacc_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [sacc_pkg::ADDR_WIDTH-1:0] addr,
   input  logic [sacc_pkg::DATA_WIDTH-1:0] data,
   output sacc_pkg::axis_type             x_axis,
   output sacc_pkg::axis_type             y_axis
);
   import sacc_pkg::*;

   logic [3:0][7:0] ax_ff, ax_in;
   logic [3:0][7:0] ay_ff, ay_in;
   logic [2:0][7:0] bx_ff, bx_in;
   logic [2:0][7:0] by_ff, by_in;
   logic [7:0]      axe_ff, axe_in, aye_ff, aye_in, bxe_ff, bxe_in, bye_ff, bye_in;

   always_comb begin
      ax_in  = ax_ff;
      ay_in  = ay_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      axe_in = axe_ff;
      aye_in = aye_ff;
      bxe_in = bxe_ff;
      bye_in = bye_ff;
      if (wr_en) begin
         case (addr)
            REG_AX_B0:    ax_in[0] = data;
            REG_AX_B1:    ax_in[1] = data;
            REG_AX_B2:    ax_in[2] = data;
            REG_AX_DELTA: ax_in[3] = data;
            REG_A_XEXT:   axe_in   = data;
            REG_A_YEXT:   aye_in   = data;
            REG_AY_B0:    ay_in[0] = data;
            REG_AY_B1:    ay_in[1] = data;
            REG_AY_B2:    ay_in[2] = data;
            REG_AY_DELTA: ay_in[3] = data;
            REG_B_XEXT:   bxe_in   = data;
            REG_B_YEXT:   bye_in   = data;
            REG_BY_B0:    by_in[0] = data;
            REG_BY_B1:    by_in[1] = data;
            REG_BY_B2:    by_in[2] = data;
            REG_BX_B0:    bx_in[0] = data;
            REG_BX_B1:    bx_in[1] = data;
            REG_BX_B2:    bx_in[2] = data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff  <= '0;
         ay_ff  <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
         axe_ff <= EXTENT_RESET;
         aye_ff <= EXTENT_RESET;
         bxe_ff <= EXTENT_RESET;
         bye_ff <= EXTENT_RESET;
      end else begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         axe_ff <= axe_in;
         aye_ff <= aye_in;
         bxe_ff <= bxe_in;
         bye_ff <= bye_in;
      end
   end

   // Byte 0 is the most significant byte of each base position
   assign x_axis = '{a_base:   {ax_ff[0], ax_ff[1], ax_ff[2]},
                     a_delta:  ax_ff[3],
                     b_base:   {bx_ff[0], bx_ff[1], bx_ff[2]},
                     a_extent: axe_ff,
                     b_extent: bxe_ff};
   assign y_axis = '{a_base:   {ay_ff[0], ay_ff[1], ay_ff[2]},
                     a_delta:  ay_ff[3],
                     b_base:   {by_ff[0], by_ff[1], by_ff[2]},
                     a_extent: aye_ff,
                     b_extent: bye_ff};
endmodule

// ===== sv/sacc_axis.sv =====
// Single-axis overlap test: range window and masked magnitude against extents.
module sacc_axis (
   input  sacc_pkg::axis_type ops,
   output logic               miss
);
   import sacc_pkg::*;

   logic signed [26:0] pos_a;
   logic signed [26:0] pos_b;
   logic signed [26:0] diff;
   logic [26:0]        mag;
   logic [8:0]         ext_sum;

   assign pos_a   = $signed({3'b000, ops.a_base}) +
                    $signed({{19{ops.a_delta[7]}}, ops.a_delta});
   assign pos_b   = $signed({3'b000, ops.b_base});
   assign diff    = pos_a - pos_b;
   assign mag     = diff[26] ? (~diff + 27'd1) : diff;
   assign ext_sum = {1'b0, ops.a_extent} + {1'b0, ops.b_extent};

   assign miss = (diff > DIFF_MAX) || (diff < DIFF_MIN) || (mag[8:0] > ext_sum);
endmodule

// ===== sv/sprite_axis_collision_checker_top.sv =====
// Top level of the sprite collision checker: request decode and response queue.
//
// Usage: each request beat is one register access (func 1 = write, 0 = read)
// with a 5-bit register address and a write byte. Every request beat gives
// exactly one response beat carrying read_data. Writes load object positions
// and extents and answer 0; a read of the status register answers 1 in bit 0
// when the objects miss on either axis, and every other read answers 0.
// Responses are registered. Throughput: one access per cycle while the skid
// register is empty, set by the single compare stage between the register file
// and the response register.
// A two-entry response queue (output register plus skid register) lets one
// request be taken while a response waits; if the receiver keeps stalling,
// req ready drops once the skid register is full and rises when it drains.
// A write is visible to a status read in the next request beat.
// Reset (synchronous, active high) clears both response entries, positions
// to zero and all four extents to one.
module sprite_axis_collision_checker_top (
   input logic        clock,
   input logic        reset,
   sacc_req_if.sink   req_chan,
   sacc_rsp_if.source rsp_chan
);
   import sacc_pkg::*;

   axis_type              x_axis, y_axis;
   logic                  x_miss, y_miss;
   logic                  accept;
   logic                  rsp_fire;
   logic [DATA_WIDTH-1:0] new_data;

   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [DATA_WIDTH-1:0] skid_data_ff, skid_data_in;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && !skid_valid_ff;
   assign rsp_fire       = out_valid_ff && rsp_chan.ready;

   sacc_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept && (req_chan.func == FUNC_WRITE)),
      .addr   (req_chan.register_address),
      .data   (req_chan.write_data),
      .x_axis (x_axis),
      .y_axis (y_axis)
   );

   sacc_axis u_axis_x (.ops(x_axis), .miss(x_miss));
   sacc_axis u_axis_y (.ops(y_axis), .miss(y_miss));

   assign new_data = ((req_chan.func == FUNC_READ) && (req_chan.register_address == REG_STATUS))
                     ? {{(DATA_WIDTH-1){1'b0}}, (x_miss || y_miss)} : '0;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_fire) begin
         // Output slot free: refill from skid first, else from the new beat
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_valid_in = 1'b1;
            out_data_in  = new_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         // Output stalled: park the new beat
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = out_data_ff;

`ifndef ASSERT_OFF
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted request left no response");

   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.func == FUNC_WRITE) && !out_valid_ff && !skid_valid_ff)
      |=> (out_data_ff == '0))
      else $error("write access answered nonzero data");

   a_upper_bits_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff[DATA_WIDTH-1:1] == '0))
      else $error("response carries nonzero upper bits");
`endif
endmodule

// ===== tb/sv/tb_sprite_axis_collision_checker_top.sv =====
// Self-checking testbench for the sprite collision checker: bus accesses in, read bytes checked.
module tb_sprite_axis_collision_checker_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sacc_pkg::*;

   // Addresses outside the register map
   localparam logic [ADDR_WIDTH-1:0] UNMAPPED_LOW  = 5'h00;
   localparam logic [ADDR_WIDTH-1:0] UNMAPPED_HIGH = 5'h1F;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] addr;
      logic [DATA_WIDTH-1:0] data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset;

   sacc_req_if req_bus ();
   sacc_rsp_if rsp_bus ();

   sprite_axis_collision_checker_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Register file as the block should hold it
   logic [7:0] ax_pos [4];
   logic [7:0] ay_pos [4];
   logic [7:0] bx_pos [3];
   logic [7:0] by_pos [3];
   logic [7:0] ax_ext, ay_ext, bx_ext, by_ext;

   logic [DATA_WIDTH-1:0] status_due_q [$];
   int mismatch_count = 0;
   int items_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   function automatic logic axis_apart(input axis_type ops);
      logic signed [26:0] pos_a, pos_b, gap;
      logic [26:0] mag;
      logic [8:0] reach;
      pos_a = $signed({3'b000, ops.a_base}) + $signed({{19{ops.a_delta[7]}}, ops.a_delta});
      pos_b = $signed({3'b000, ops.b_base});
      gap = pos_a - pos_b;
      mag = gap[26] ? 27'(-gap) : 27'(gap);
      reach = {1'b0, ops.a_extent} + {1'b0, ops.b_extent};
      return (gap > DIFF_MAX) || (gap < DIFF_MIN) || (mag[8:0] > reach);
   endfunction

   // Apply one access to the register file and return the byte it must read back
   function automatic logic [DATA_WIDTH-1:0] apply_access(input logic kind,
         input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] data);
      logic [DATA_WIDTH-1:0] rd;
      axis_type x_ops, y_ops;
      rd = '0;
      if (kind == FUNC_WRITE) begin
         case (addr)
            REG_AX_B0:    ax_pos[0] = data;
            REG_AX_B1:    ax_pos[1] = data;
            REG_AX_B2:    ax_pos[2] = data;
            REG_AX_DELTA: ax_pos[3] = data;
            REG_A_XEXT:   ax_ext = data;
            REG_A_YEXT:   ay_ext = data;
            REG_AY_B0:    ay_pos[0] = data;
            REG_AY_B1:    ay_pos[1] = data;
            REG_AY_B2:    ay_pos[2] = data;
            REG_AY_DELTA: ay_pos[3] = data;
            REG_B_XEXT:   bx_ext = data;
            REG_B_YEXT:   by_ext = data;
            REG_BY_B0:    by_pos[0] = data;
            REG_BY_B1:    by_pos[1] = data;
            REG_BY_B2:    by_pos[2] = data;
            REG_BX_B0:    bx_pos[0] = data;
            REG_BX_B1:    bx_pos[1] = data;
            REG_BX_B2:    bx_pos[2] = data;
            default: ;
         endcase
      end else if (addr == REG_STATUS) begin
         x_ops = '{a_base: {ax_pos[0], ax_pos[1], ax_pos[2]}, a_delta: ax_pos[3],
                   b_base: {bx_pos[0], bx_pos[1], bx_pos[2]},
                   a_extent: ax_ext, b_extent: bx_ext};
         y_ops = '{a_base: {ay_pos[0], ay_pos[1], ay_pos[2]}, a_delta: ay_pos[3],
                   b_base: {by_pos[0], by_pos[1], by_pos[2]},
                   a_extent: ay_ext, b_extent: by_ext};
         rd[0] = axis_apart(x_ops) | axis_apart(y_ops);
      end
      return rd;
   endfunction

   // Entered and left at a falling edge; valid stays high into the next call
   task automatic issue_access(input logic kind, input logic [ADDR_WIDTH-1:0] addr,
                               input logic [DATA_WIDTH-1:0] data);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid            <= 1'b0;
         req_bus.func             <= 1'($urandom_range(1));
         req_bus.register_address <= ADDR_WIDTH'($urandom_range(31));
         req_bus.write_data       <= DATA_WIDTH'($urandom_range(255));
         @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.func             <= kind;
      req_bus.register_address <= addr;
      req_bus.write_data       <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      status_due_q.push_back(apply_access(kind, addr, data));
      items_sent++;
      @(negedge clock);
   endtask

   // Write all position bytes of one axis in shuffled order
   task automatic load_axis(input logic on_x, input logic [23:0] a_base,
                            input logic [7:0] a_delta, input logic [23:0] b_base);
      reg_write_type pending [$];
      int pick;
      pending.push_back('{on_x ? REG_AX_B0 : REG_AY_B0, a_base[23:16]});
      pending.push_back('{on_x ? REG_AX_B1 : REG_AY_B1, a_base[15:8]});
      pending.push_back('{on_x ? REG_AX_B2 : REG_AY_B2, a_base[7:0]});
      pending.push_back('{on_x ? REG_AX_DELTA : REG_AY_DELTA, a_delta});
      pending.push_back('{on_x ? REG_BX_B0 : REG_BY_B0, b_base[23:16]});
      pending.push_back('{on_x ? REG_BX_B1 : REG_BY_B1, b_base[15:8]});
      pending.push_back('{on_x ? REG_BX_B2 : REG_BY_B2, b_base[7:0]});
      while (pending.size() != 0) begin
         pick = int'($urandom_range(pending.size() - 1));
         issue_access(FUNC_WRITE, pending[pick].addr, pending[pick].data);
         pending.delete(pick);
      end
   endtask

   task automatic test_reset_values();
      issue_access(FUNC_READ, REG_STATUS, 8'hFF);
      issue_access(FUNC_READ, REG_A_XEXT, 8'h00);
   endtask

   // Upper edge of the window, and a negative delta pulling back inside
   task automatic test_x_upper_window();
      issue_access(FUNC_WRITE, REG_A_XEXT, 8'hFF);
      issue_access(FUNC_WRITE, REG_B_XEXT, 8'hFF);
      issue_access(FUNC_WRITE, REG_AX_B1, 8'h01);
      issue_access(FUNC_WRITE, REG_AX_B2, 8'hFE);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_AX_DELTA, 8'h01);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_AX_DELTA, 8'h02);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_AX_DELTA, 8'h80);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
   endtask

   // Lower edge: magnitude wraps through the 9-bit mask before the range cut
   task automatic test_x_lower_window();
      issue_access(FUNC_WRITE, REG_AX_B1, 8'h00);
      issue_access(FUNC_WRITE, REG_AX_B2, 8'h00);
      issue_access(FUNC_WRITE, REG_AX_DELTA, 8'h00);
      issue_access(FUNC_WRITE, REG_BX_B1, 8'h03);
      issue_access(FUNC_WRITE, REG_BX_B2, 8'hFE);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_AX_DELTA, 8'hFF);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_BX_B2, 8'hFF);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
   endtask

   // Full-scale positions, zero extents, negative position of A
   task automatic test_y_extremes();
      load_axis(1'b0, 24'hFFFFFF, 8'h7F, 24'hFFFFFF);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_A_YEXT, 8'h40);
      issue_access(FUNC_WRITE, REG_B_YEXT, 8'h40);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      load_axis(1'b0, 24'h000000, 8'h80, 24'h000000);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_WRITE, REG_B_YEXT, 8'h00);
      issue_access(FUNC_WRITE, REG_A_YEXT, 8'h00);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
   endtask

   task automatic test_unmapped_access();
      issue_access(FUNC_WRITE, UNMAPPED_LOW, 8'hFF);
      issue_access(FUNC_WRITE, UNMAPPED_HIGH, 8'hAA);
      issue_access(FUNC_WRITE, REG_STATUS, 8'h55);
      issue_access(FUNC_READ, REG_STATUS, 8'h00);
      issue_access(FUNC_READ, UNMAPPED_HIGH, 8'h00);
      issue_access(FUNC_READ, REG_BX_B2, 8'h00);
   endtask

   // Extents and positions laid out near the window, then status reads and now and then a read of a random address
   task automatic test_random_geometry(input int count);
      int stop_at, reach, offset;
      logic [7:0] delta;
      logic [23:0] b_base;
      logic on_x;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         for (int axis = 0; axis < 2; axis++) begin
            on_x = (axis == 0);
            if ($urandom_range(1) == 1) begin
               issue_access(FUNC_WRITE, on_x ? REG_A_XEXT : REG_A_YEXT,
                            DATA_WIDTH'($urandom_range(255)));
               issue_access(FUNC_WRITE, on_x ? REG_B_XEXT : REG_B_YEXT,
                            DATA_WIDTH'($urandom_range(255)));
            end
            if ($urandom_range(3) != 0) begin
               reach = on_x ? int'(ax_ext) + int'(bx_ext) : int'(ay_ext) + int'(by_ext);
               case ($urandom_range(3))
                  0: offset = int'($urandom_range(1700)) - 1100;
                  1, 2: offset = int'($urandom_range(2 * reach + 4)) - (reach + 2);
                  default: begin
                     case ($urandom_range(2))
                        0: offset = -1024;
                        1: offset = -513;
                        default: offset = 510;
                     endcase
                     offset += int'($urandom_range(2));
                  end
               endcase
               case ($urandom_range(3))
                  0: b_base = 24'($urandom_range(4095));
                  1: b_base = 24'hFFFFFF - 24'($urandom_range(4095));
                  default: b_base = 24'($urandom);
               endcase
               delta = 8'($urandom_range(255));
               load_axis(on_x, b_base + 24'(offset - int'($signed(delta))), delta, b_base);
            end
         end
         repeat ($urandom_range(1, 2))
            issue_access(FUNC_READ, REG_STATUS, DATA_WIDTH'($urandom_range(255)));
         if ($urandom_range(7) == 0)
            issue_access(FUNC_READ, ADDR_WIDTH'($urandom_range(31)),
                         DATA_WIDTH'($urandom_range(255)));
      end
   endtask

   task automatic test_bus_noise(input int count);
      repeat (count)
         issue_access(1'($urandom_range(1)), ADDR_WIDTH'($urandom_range(31)),
                      DATA_WIDTH'($urandom_range(255)));
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : response_check
      logic [DATA_WIDTH-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_due_q.size() == 0) begin
            $display("%0t: response with none pending, expected none, actual %02h",
                     $time, rsp_bus.read_data);
            mismatch_count++;
         end else begin
            want = status_due_q.pop_front();
            if (rsp_bus.read_data !== want) begin
               $display("%0t: read_data mismatch, expected %02h, actual %02h",
                        $time, want, rsp_bus.read_data);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("sprite_axis_collision_checker_top test failed");
      $finish;
   end

   initial begin
      int phase_idle [4];
      int phase_stall [4];
      int waited;
      phase_idle  = '{0, 64, 0, 12};
      phase_stall = '{0, 0, 64, 12};
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.func             = FUNC_READ;
      req_bus.register_address = '0;
      req_bus.write_data       = '0;
      rsp_bus.ready            = 1'b0;
      ax_pos = '{default: 8'h00};
      ay_pos = '{default: 8'h00};
      bx_pos = '{default: 8'h00};
      by_pos = '{default: 8'h00};
      ax_ext = EXTENT_RESET;
      ay_ext = EXTENT_RESET;
      bx_ext = EXTENT_RESET;
      by_ext = EXTENT_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_x_upper_window();
      test_x_lower_window();
      test_y_extremes();
      test_unmapped_access();
      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         test_random_geometry(300);
         test_bus_noise(80);
      end

      // Drop valid and drain
      req_bus.valid <= 1'b0;
      stall_pct = 0;
      waited = 0;
      while (status_due_q.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (status_due_q.size() != 0) begin
         $display("%0t: %0d responses missing, expected %02h first, actual none",
                  $time, status_due_q.size(), status_due_q[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("sprite_axis_collision_checker_top test passed");
      end else begin
         $display("sprite_axis_collision_checker_top test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sacc_pkg.sv
sv/sacc_req_if.sv
sv/sacc_rsp_if.sv
sv/sacc_regs.sv
sv/sacc_axis.sv
sv/sprite_axis_collision_checker_top.sv
tb/sv/tb_sprite_axis_collision_checker_top.sv
